>>> design/i2c_master_bit_sequencer_defines.svh
// Assertion macros shared by the sequencer modules.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define I2CMS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define I2CMS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/i2cms_pkg.sv
`timescale 1ns / 1ps

package i2cms_pkg;

	// Bus command codes; code 7 carries no meaning and is dropped.
	typedef enum logic [2:0] {
		OP_START = 3'd0,
		OP_STOP  = 3'd1,
		OP_ACK   = 3'd2,
		OP_NACK  = 3'd3,
		OP_WAIT  = 3'd4,
		OP_WRITE = 3'd5,
		OP_READ  = 3'd6
	} op_t;

	localparam int unsigned QUEUE_DEPTH_DEF = 2;
	localparam logic [2:0]  LAST_BIT        = 3'd7;

	// Classified command handed from front to back.
	// data: write byte, masked read byte, or ack flag in bit 0 for wait ack.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       sda_hold;
	} cmd_t;

	// Phases per bit group (write and read repeat their group eight times).
	function automatic logic [2:0] group_len(input op_t op);
		logic [2:0] len;
		len = 3'd2;
		unique case (op)
			OP_START, OP_STOP:         len = 3'd2;
			OP_ACK:                    len = 3'd5;
			OP_NACK, OP_WAIT, OP_READ: len = 3'd3;
			OP_WRITE:                  len = 3'd4;
			default:                   len = 3'd2;
		endcase
		return len;
	endfunction

	// Drive levels {scl, sda} for one phase.
	function automatic logic [1:0] phase_levels(input op_t op, input logic [2:0] step,
			input logic bitval);
		logic [1:0] lv;
		lv = 2'b00;
		unique case (op)
			OP_START: lv = (step == 3'd0) ? 2'b11 : 2'b10;
			OP_STOP:  lv = (step == 3'd0) ? 2'b10 : 2'b11;
			OP_ACK: begin
				case (step)
					3'd0:    lv = 2'b01;
					3'd1:    lv = 2'b00;
					3'd2:    lv = 2'b10;
					3'd3:    lv = 2'b00;
					default: lv = 2'b01;
				endcase
			end
			OP_NACK, OP_WAIT: lv = (step == 3'd1) ? 2'b11 : 2'b01;
			OP_WRITE: begin
				case (step)
					3'd0:    lv = 2'b00;
					3'd2:    lv = {1'b1, bitval};
					default: lv = {1'b0, bitval};
				endcase
			end
			OP_READ: lv = {(step == 3'd1), bitval};
			default: lv = 2'b00;
		endcase
		return lv;
	endfunction

endpackage

>>> design/i2cms_front.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          opcode,
	input  logic [7:0]          write_byte,
	input  logic [7:0]          response_bits,
	input  logic                q_full,
	output logic                push,
	output i2cms_pkg::cmd_t     push_cmd
);

	logic sda_pred_q;
	logic known_op;
	logic sda_next;
	i2cms_pkg::op_t op;

	assign op       = i2cms_pkg::op_t'(opcode);
	assign in_stall = q_full;

	// Classify the command and predict the SDA drive it leaves behind.
	always_comb begin
		known_op          = 1'b1;
		sda_next          = sda_pred_q;
		push_cmd.op       = op;
		push_cmd.data     = 8'h00;
		push_cmd.sda_hold = sda_pred_q;
		unique case (op)
			i2cms_pkg::OP_START: sda_next = 1'b0;
			i2cms_pkg::OP_STOP, i2cms_pkg::OP_ACK, i2cms_pkg::OP_NACK: sda_next = 1'b1;
			i2cms_pkg::OP_WAIT: begin
				sda_next      = 1'b1;
				push_cmd.data = {7'b0, ~response_bits[0]};
			end
			i2cms_pkg::OP_WRITE: begin
				sda_next      = write_byte[0];
				push_cmd.data = write_byte;
			end
			i2cms_pkg::OP_READ: push_cmd.data = response_bits & {8{sda_pred_q}};
			default: known_op = 1'b0;
		endcase
	end

	assign push = in_valid && !q_full && known_op;

	// Track SDA drive as of the end of the last queued command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sda_pred_q <= 1'b0;
		end else if (push) begin
			sda_pred_q <= sda_next;
		end
	end

	`I2CMS_ASSERT_NEXT(a_write_sda, push && (op == i2cms_pkg::OP_WRITE), sda_pred_q == $past(write_byte[0]), "front: SDA prediction after write wrong")

endmodule

>>> design/i2cms_queue.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_queue #(
	parameter int unsigned DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  i2cms_pkg::cmd_t push_cmd,
	input  logic            pop,
	output logic            full,
	output logic            head_valid,
	output i2cms_pkg::cmd_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	i2cms_pkg::cmd_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	// Store entries.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`I2CMS_ASSERT_NOW(a_no_underflow, pop, count_q != '0, "queue: pop while empty")
	`I2CMS_ASSERT_NOW(a_no_overflow, push, !full, "queue: push while full")

endmodule

>>> design/i2cms_back.sv
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_defines.svh"

module i2cms_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  i2cms_pkg::cmd_t head,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_stall,
	output logic            scl_level,
	output logic            sda_level,
	output logic            last_phase,
	output logic [7:0]      read_data,
	output logic            ack_seen
);

	logic [2:0] step_q;
	logic [2:0] bit_q;
	logic       out_valid_q;
	logic       scl_q;
	logic       sda_q;
	logic       last_q;
	logic [7:0] rdata_q;
	logic       ack_q;

	logic       advance;
	logic       multi;
	logic       last_step;
	logic       last;
	logic       bitval;
	logic [2:0] len;
	logic [1:0] lv;

	// Decode the current phase of the head command.
	always_comb begin
		len       = i2cms_pkg::group_len(head.op);
		multi     = (head.op == i2cms_pkg::OP_WRITE) || (head.op == i2cms_pkg::OP_READ);
		last_step = (step_q == len - 3'd1);
		last      = last_step && (!multi || (bit_q == i2cms_pkg::LAST_BIT));
		bitval    = (head.op == i2cms_pkg::OP_WRITE) ? head.data[3'd7 - bit_q]
				: head.sda_hold;
		lv        = i2cms_pkg::phase_levels(head.op, step_q, bitval);
	end

	assign advance = head_valid && (!out_valid_q || !out_stall);
	assign pop     = advance && last;

	// Step through phases and bit groups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			bit_q  <= '0;
		end else if (advance) begin
			if (last) begin
				step_q <= '0;
				bit_q  <= '0;
			end else if (last_step) begin
				step_q <= '0;
				bit_q  <= bit_q + 3'd1;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end
	end

	// Hold the output transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_q   <= lv[1];
			sda_q   <= lv[0];
			last_q  <= last;
			rdata_q <= (last && (head.op == i2cms_pkg::OP_READ)) ? head.data : 8'h00;
			ack_q   <= last && (head.op == i2cms_pkg::OP_WAIT) && head.data[0];
		end
	end

	assign out_valid  = out_valid_q;
	assign scl_level  = scl_q;
	assign sda_level  = sda_q;
	assign last_phase = last_q;
	assign read_data  = rdata_q;
	assign ack_seen   = ack_q;

	`I2CMS_ASSERT_NOW(a_step_in_range, head_valid, step_q < len, "back: phase step past group length")
	`I2CMS_ASSERT_NOW(a_bits_only_multi, head_valid && (bit_q != 3'd0), multi, "back: bit count on single-group command")

endmodule

>>> design/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// I2C master bit sequencer.
// Input channel (in_valid / in_stall): one bus command per transaction with
// opcode, write_byte and response_bits. Opcode 7 is accepted and dropped.
// Output channel (out_valid / out_stall): one phase per transaction with the
// SCL and SDA drive levels; last_phase marks the final phase of a command,
// which also carries read_data (read byte) or ack_seen (wait ack).
// A command expands to 2 (start, stop), 5 (ack), 3 (nack, wait ack),
// 24 (read) or 32 (write) phases, emitted by the phase counter in the back
// end at one phase per cycle unless out_stall holds it. The first phase of
// a command passes the queue entry and then the back-end output registers.
// Commands are classified and queued (QUEUE_DEPTH entries), so new commands
// are taken while earlier ones are still being emitted; in_stall rises only
// when the queue is full. When out_stall is high the current phase holds and
// the back end pauses; the front keeps filling the queue.
// Reset clears the queue, the phase counters and the output valid, and sets
// the tracked SDA drive low.

module i2c_master_bit_sequencer #(
	parameter int unsigned QUEUE_DEPTH = i2cms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] opcode,
	input  logic [7:0] write_byte,
	input  logic [7:0] response_bits,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       scl_level,
	output logic       sda_level,
	output logic       last_phase,
	output logic [7:0] read_data,
	output logic       ack_seen
);

	logic            push;
	logic            pop;
	logic            q_full;
	logic            head_valid;
	i2cms_pkg::cmd_t push_cmd;
	i2cms_pkg::cmd_t head;

	i2cms_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.write_byte    (write_byte),
		.response_bits (response_bits),
		.q_full        (q_full),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	i2cms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	i2cms_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.scl_level  (scl_level),
		.sda_level  (sda_level),
		.last_phase (last_phase),
		.read_data  (read_data),
		.ack_seen   (ack_seen)
	);

endmodule

>>> sim/tb_i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer;

	// Opcode with no meaning; the block drops it.
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int unsigned TARGET_CMDS = 450;
	localparam int unsigned DRAIN_CYCLES = 40;

	typedef struct {
		logic       scl;
		logic       sda;
		logic       last;
		logic [7:0] rd;
		logic       ack;
	} phase_t;

	// Expected bus phases, worked out per accepted command.
	class phase_scoreboard;
		phase_t      phase_q[$];
		logic        sda_drive;
		logic        scl_drive;
		int unsigned errors;

		function new();
			sda_drive = 1'b0;
			scl_drive = 1'b0;
			errors = 0;
		endfunction

		function void push_phase(logic scl, logic sda, logic last, logic [7:0] rd, logic ack);
			phase_t p;
			p.scl = scl;
			p.sda = sda;
			p.last = last;
			p.rd = rd;
			p.ack = ack;
			scl_drive = scl;
			sda_drive = sda;
			phase_q.push_back(p);
		endfunction

		// Expand one accepted command into its phase run.
		function void note_command(logic [2:0] op, logic [7:0] wb, logic [7:0] rb);
			logic       b;
			logic       s;
			logic       level;
			logic [7:0] rd_byte;
			int         i;
			case (op)
				i2cms_pkg::OP_START: begin
					push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
					push_phase(1'b1, 1'b0, 1'b1, 8'h00, 1'b0);
				end
				i2cms_pkg::OP_STOP: begin
					push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
					push_phase(1'b1, 1'b1, 1'b1, 8'h00, 1'b0);
				end
				i2cms_pkg::OP_ACK: begin
					push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
					push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
					push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b0);
					push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
					push_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
				end
				i2cms_pkg::OP_NACK: begin
					push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
					push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
					push_phase(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
				end
				i2cms_pkg::OP_WAIT: begin
					push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
					push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0);
					// sample the wired-AND of slave and master drive
					level = rb[0] & sda_drive;
					push_phase(1'b0, 1'b1, 1'b1, 8'h00, ~level);
				end
				i2cms_pkg::OP_WRITE: begin
					for (i = 0; i < 8; i++) begin
						b = wb[7 - i];
						push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
						push_phase(1'b0, b, 1'b0, 8'h00, 1'b0);
						push_phase(1'b1, b, 1'b0, 8'h00, 1'b0);
						push_phase(1'b0, b, i == 7, 8'h00, 1'b0);
					end
				end
				i2cms_pkg::OP_READ: begin
					// master keeps its SDA drive through the whole byte
					s = sda_drive;
					rd_byte = 8'h00;
					for (i = 0; i < 8; i++) begin
						push_phase(1'b0, s, 1'b0, 8'h00, 1'b0);
						push_phase(1'b1, s, 1'b0, 8'h00, 1'b0);
						rd_byte[7 - i] = rb[7 - i] & s;
						push_phase(1'b0, s, i == 7, (i == 7) ? rd_byte : 8'h00, 1'b0);
					end
				end
				default: begin
					// dropped command: no phases, state unchanged
				end
			endcase
		endfunction

		// Compare one accepted phase with the oldest expectation.
		function void check_phase(phase_t got);
			phase_t want;
			if (phase_q.size() == 0) begin
				$display("%0t: unexpected phase scl=%0b sda=%0b last=%0b rd=%02h ack=%0b",
					$time, got.scl, got.sda, got.last, got.rd, got.ack);
				errors++;
				return;
			end
			want = phase_q.pop_front();
			if (got.scl !== want.scl) begin
				$display("%0t: scl_level expected %0b actual %0b", $time, want.scl, got.scl);
				errors++;
			end
			if (got.sda !== want.sda) begin
				$display("%0t: sda_level expected %0b actual %0b", $time, want.sda, got.sda);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last_phase expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
			if (got.rd !== want.rd) begin
				$display("%0t: read_data expected %02h actual %02h", $time, want.rd, got.rd);
				errors++;
			end
			if (got.ack !== want.ack) begin
				$display("%0t: ack_seen expected %0b actual %0b", $time, want.ack, got.ack);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return phase_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] opcode = i2cms_pkg::OP_START;
	logic [7:0] write_byte = 8'h00;
	logic [7:0] response_bits = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       scl_level;
	logic       sda_level;
	logic       last_phase;
	logic [7:0] read_data;
	logic       ack_seen;

	phase_scoreboard sb = new();
	int unsigned     cmds_sent = 0;
	int unsigned     send_count = 0;
	bit              send_quiet = 1'b0;

	i2c_master_bit_sequencer uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.write_byte    (write_byte),
		.response_bits (response_bits),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.scl_level     (scl_level),
		.sda_level     (sda_level),
		.last_phase    (last_phase),
		.read_data     (read_data),
		.ack_seen      (ack_seen)
	);

	always #6 clk = ~clk;

	// Draw a random byte.
	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Hand one command to the block and log it once accepted.
	task automatic send_cmd(input logic [2:0] op, input logic [7:0] wb, input logic [7:0] rb);
		int unsigned gap;
		// re-draw between idling and back-to-back stretches
		if (send_count % 40 == 0)
			send_quiet = ($urandom_range(0, 3) == 0);
		send_count++;
		gap = send_quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		write_byte <= wb;
		response_bits <= rb;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_command(op, wb, rb);
		if (op != OP_UNUSED)
			cmds_sent++;
	endtask

	// Hold off the sender until every pending phase is out.
	task automatic drain_phases();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
	endtask

	// One well-formed transfer: start, address, ack check, data bytes, stop.
	task automatic run_transfer();
		logic [7:0] addr;
		int unsigned nbytes;
		int unsigned k;
		addr = rand_byte();
		nbytes = $urandom_range(1, 4);
		send_cmd(i2cms_pkg::OP_START, rand_byte(), rand_byte());
		send_cmd(i2cms_pkg::OP_WRITE, addr, rand_byte());
		send_cmd(i2cms_pkg::OP_WAIT, rand_byte(), rand_byte());
		for (k = 0; k < nbytes; k++) begin
			if (addr[0]) begin
				send_cmd(i2cms_pkg::OP_READ, rand_byte(), rand_byte());
				if (k == nbytes - 1)
					send_cmd(i2cms_pkg::OP_NACK, rand_byte(), rand_byte());
				else
					send_cmd(i2cms_pkg::OP_ACK, rand_byte(), rand_byte());
			end else begin
				send_cmd(i2cms_pkg::OP_WRITE, rand_byte(), rand_byte());
				send_cmd(i2cms_pkg::OP_WAIT, rand_byte(), rand_byte());
			end
		end
		send_cmd(i2cms_pkg::OP_STOP, rand_byte(), rand_byte());
	endtask

	// Stimulus: directed commands, then random transfers mixed with noise.
	initial begin
		int unsigned n;
		int unsigned k;
		bit          drained;
		drained = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// read and wait ack with SDA driven low after reset, then after start
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hFF);
		send_cmd(i2cms_pkg::OP_WAIT, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_WAIT, 8'hFF, 8'h01);
		send_cmd(i2cms_pkg::OP_READ, 8'hFF, 8'hFF);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_START, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hFF);
		send_cmd(i2cms_pkg::OP_ACK, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_NACK, 8'hFF, 8'hFF);
		send_cmd(i2cms_pkg::OP_WRITE, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'hA5);
		send_cmd(i2cms_pkg::OP_WRITE, 8'hFF, 8'hFF);
		send_cmd(i2cms_pkg::OP_READ, 8'h00, 8'h5A);
		send_cmd(i2cms_pkg::OP_WRITE, 8'hA5, 8'h00);
		send_cmd(OP_UNUSED, 8'hFF, 8'hFF);
		send_cmd(i2cms_pkg::OP_WAIT, 8'h00, 8'hFE);
		send_cmd(i2cms_pkg::OP_STOP, 8'hFF, 8'h00);
		send_cmd(i2cms_pkg::OP_START, 8'hFF, 8'hFF);
		send_cmd(OP_UNUSED, 8'h00, 8'h00);
		send_cmd(i2cms_pkg::OP_STOP, 8'h00, 8'hFF);

		// random part
		while (cmds_sent < TARGET_CMDS) begin
			if (!drained && cmds_sent >= TARGET_CMDS / 2) begin
				drain_phases();
				drained = 1'b1;
			end
			if ($urandom_range(0, 3) != 0) begin
				run_transfer();
			end else begin
				n = $urandom_range(1, 4);
				for (k = 0; k < n; k++)
					send_cmd(3'($urandom_range(0, 7)), rand_byte(), rand_byte());
			end
		end

		// drain and let any late phase show up
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: random stall per phase, with stretches of none.
	initial begin
		int unsigned stall;
		int unsigned recv_count;
		bit          recv_quiet;
		phase_t      got;
		recv_count = 0;
		recv_quiet = 1'b0;
		forever begin
			if (recv_count % 50 == 0)
				recv_quiet = ($urandom_range(0, 3) == 0);
			recv_count++;
			stall = recv_quiet ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				out_stall <= 1'b1;
				repeat (stall) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.scl = scl_level;
			got.sda = sda_level;
			got.last = last_phase;
			got.rd = read_data;
			got.ack = ack_seen;
			sb.check_phase(got);
		end
	end

	// Hard stop for a hung run.
	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
